// File: hw/rtl/length_prefixed_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_defines
// Assertion macros used by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LPFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lpfd check failed");

// next-cycle implication
`define LPFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lpfd check failed");

`endif

// File: hw/rtl/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// Types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  localparam logic [7:0] DefaultMarker = 8'h46;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_GOOD    = 2'd2,
    EV_BAD     = 2'd3
  } event_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] start_marker;
  } cfg_item_t;

  typedef struct packed {
    event_e      event_res;
    logic [15:0] payload_offset;
    logic [7:0]  payload_byte;
    logic [16:0] frame_length;
  } res_item_t;

  // registered input beat handed to the core
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } in_beat_t;

endpackage

// File: hw/rtl/lpfd_stream_if.sv
// ----------------------------------------------------------------------------
// lpfd_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface lpfd_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/length_prefixed_frame_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Start marker, 16-bit length, payload and 8-bit additive checksum deframer.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i  carries one received byte per beat. Every byte yields exactly one
//         beat on res_o: event (none, payload byte, frame good, frame bad),
//         payload offset and byte, and the current frame length.
//   cfg_i writes the start marker; it is always ready and is meant to be
//         written only while no byte is in flight.
// Path: an accepted byte waits in the input register and moves on into the
//   result register once res_o is not stalled.
// Throughput: one byte per cycle while res_o is not stalled, set by the single
//   state update in the core between the two registers.
// Reset: the block hunts for the marker (0x46 after reset), frame length
//   reads zero and both registers are empty.
// Stall: a stalled result holds; the input register still takes one more byte
//   if it was empty, after which rx_i.ready drops until res_o.ready returns.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer import lpfd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  lpfd_stream_if.sink   cfg_i,
  lpfd_stream_if.sink   rx_i,
  lpfd_stream_if.source res_o
);

  logic [7:0] marker_q;
  in_beat_t   beat;
  logic       take;
  cfg_item_t  cfg_item;
  rx_item_t   rx_item;
  res_item_t  res_item;

  assign cfg_item    = cfg_i.payload;
  assign rx_item     = rx_i.payload;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= DefaultMarker;
    end else if (cfg_i.valid) begin
      marker_q <= cfg_item.start_marker;
    end
  end

  lpfd_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rx_i.valid),
    .data_i  (rx_item.rx_byte),
    .ready_o (rx_i.ready),
    .beat_o  (beat),
    .take_i  (take)
  );

  lpfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .take_o      (take),
    .marker_i    (marker_q),
    .res_valid_o (res_o.valid),
    .res_o       (res_item),
    .res_ready_i (res_o.ready)
  );

  assign res_o.payload = res_item;

endmodule

// File: hw/rtl/lpfd_in_stage.sv
// ----------------------------------------------------------------------------
// lpfd_in_stage
// Input register for received bytes; refills in the cycle the core takes one.
// ----------------------------------------------------------------------------
module lpfd_in_stage import lpfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] data_i,
  output logic       ready_o,
  output in_beat_t   beat_o,
  input  logic       take_i
);

  logic       vld_q, vld_d;
  logic [7:0] data_q;
  logic       load;

  assign ready_o = !vld_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign beat_o.valid = vld_q;
  assign beat_o.data  = data_q;

endmodule

// File: hw/rtl/lpfd_core.sv
// ----------------------------------------------------------------------------
// lpfd_core
// Frame state, checksum and result register; one byte per cycle while the result is not stalled.
// ----------------------------------------------------------------------------
module lpfd_core import lpfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_beat_t   beat_i,
  output logic       take_o,
  input  logic [7:0] marker_i,
  output logic       res_valid_o,
  output res_item_t  res_o,
  input  logic       res_ready_i
);

  localparam logic [1:0] PhHunt  = 2'd0;
  localparam logic [1:0] PhLenHi = 2'd1;
  localparam logic [1:0] PhLenLo = 2'd2;
  localparam logic [1:0] PhBody  = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [16:0] count_q, count_d;
  logic [16:0] offset_q, offset_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  sum_add;
  logic        res_vld_q, res_vld_d;
  res_item_t   res_q, res_d;

  assign take_o  = beat_i.valid && (!res_vld_q || res_ready_i);
  assign sum_add = sum_q + beat_i.data;

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    offset_d = offset_q;
    sum_d    = sum_q;
    res_d.event_res      = EV_NONE;
    res_d.payload_offset = '0;
    res_d.payload_byte   = '0;
    unique case (phase_q)
      PhHunt: begin
        if (beat_i.data == marker_i) begin
          sum_d   = beat_i.data;
          phase_d = PhLenHi;
        end
      end
      PhLenHi: begin
        count_d = {1'b0, beat_i.data, 8'h00};
        sum_d   = sum_add;
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        count_d  = {1'b0, count_q[15:8], beat_i.data} + 17'd1;
        sum_d    = sum_add;
        offset_d = '0;
        phase_d  = PhBody;
      end
      PhBody: begin
        if (offset_q < count_q) begin
          res_d.event_res      = EV_PAYLOAD;
          res_d.payload_offset = offset_q[15:0];
          res_d.payload_byte   = beat_i.data;
          sum_d                = sum_add;
          offset_d             = offset_q + 17'd1;
        end else begin
          // checksum beat closes the frame
          res_d.event_res = (sum_add == 8'h00) ? EV_GOOD : EV_BAD;
          phase_d         = PhHunt;
        end
      end
    endcase
    res_d.frame_length = count_d;
  end

  always_comb begin
    res_vld_d = res_vld_q;
    if (take_o) begin
      res_vld_d = 1'b1;
    end else if (res_ready_i) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      count_q   <= '0;
      sum_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
      if (take_o) begin
        phase_q <= phase_d;
        count_q <= count_d;
        sum_q   <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      offset_q <= offset_d;
      res_q    <= res_d;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

// File: hw/rtl/lpfd_checker.sv
// ----------------------------------------------------------------------------
// lpfd_checker
// Port-level checks on the deframer result channel.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_deframer_defines.svh"

module lpfd_checker import lpfd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      res_valid_i,
  input logic      res_ready_i,
  input res_item_t res_i
);

  logic is_payload;
  logic is_end;

  assign is_payload = res_i.event_res == EV_PAYLOAD;
  assign is_end     = (res_i.event_res == EV_GOOD) || (res_i.event_res == EV_BAD);

  `LPFD_ASSERT_NEXT(a_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(res_i))
  `LPFD_ASSERT_NOW(a_clean, res_valid_i && !is_payload, (res_i.payload_offset == 16'd0) && (res_i.payload_byte == 8'd0))
  `LPFD_ASSERT_NOW(a_offset, res_valid_i && is_payload, {1'b0, res_i.payload_offset} < res_i.frame_length)
  `LPFD_ASSERT_NOW(a_length, res_valid_i && is_end, res_i.frame_length != 17'd0)

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_i       (res_o.payload)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the length-prefixed frame deframer. Byte streams of
// whole, corrupted and cut-off frames plus line noise are fed through the rx
// channel under several start markers, while both channels idle in random
// bursts. Every byte is run through a local deframer model and each result
// beat is compared field by field against the oldest predicted beat.
// ----------------------------------------------------------------------------
module tb_top;
  import lpfd_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int unsigned CycleLimit = 500000;
  localparam logic [16:0] PosHunt    = 17'd0;
  localparam logic [16:0] PosLenHi   = 17'd1;
  localparam logic [16:0] PosLenLo   = 17'd2;
  localparam logic [16:0] HeaderLen  = 17'd3;

  logic clk_i;
  logic rst_ni;

  lpfd_stream_if #(.payload_t(cfg_item_t)) cfg_if ();
  lpfd_stream_if #(.payload_t(rx_item_t))  rx_if ();
  lpfd_stream_if #(.payload_t(res_item_t)) res_if ();

  length_prefixed_frame_deframer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  // deframer model state
  logic [7:0]  marker_cfg;
  logic [16:0] hunt_pos;
  logic [16:0] frame_count;
  logic [7:0]  frame_sum;

  byte_q_t     pending_bytes;
  res_item_t   predicted_beats[$];

  bit          calm;
  bit          rx_took;
  int          rx_gap;
  int          res_stall;
  int unsigned cycles;
  int          errors;
  int          bytes_in;
  int          payload_beats;
  int          frames_good;
  int          frames_bad;
  int          marker_writes;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic deframe_byte(input logic [7:0] b);
    res_item_t r;
    r = '0;
    r.event_res = EV_NONE;
    if (hunt_pos == PosHunt) begin
      if (b == marker_cfg) begin
        frame_sum = b;
        hunt_pos  = PosLenHi;
      end
    end else if (hunt_pos == PosLenHi) begin
      frame_count = {1'b0, b, 8'h00};
      frame_sum   = frame_sum + b;
      hunt_pos    = PosLenLo;
    end else if (hunt_pos == PosLenLo) begin
      frame_count = {1'b0, frame_count[15:8], b} + 17'd1;
      frame_sum   = frame_sum + b;
      hunt_pos    = HeaderLen;
    end else if ({1'b0, hunt_pos} < {1'b0, frame_count} + {1'b0, HeaderLen}) begin
      r.event_res      = EV_PAYLOAD;
      r.payload_offset = 16'(hunt_pos - HeaderLen);
      r.payload_byte   = b;
      frame_sum        = frame_sum + b;
      hunt_pos         = hunt_pos + 17'd1;
    end else if ({1'b0, hunt_pos} == {1'b0, frame_count} + {1'b0, HeaderLen}) begin
      r.event_res = (8'(frame_sum + b) == 8'd0) ? EV_GOOD : EV_BAD;
      hunt_pos    = PosHunt;
    end else begin
      hunt_pos = PosHunt;
    end
    r.frame_length = frame_count;
    predicted_beats.push_back(r);
  endtask

  task automatic check_field(input string what, input logic [16:0] want,
                             input logic [16:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 30) begin
        $display("%0t mismatch %s: expected %0h, actual %0h", $time, what, want, got);
      end
    end
  endtask

  function automatic byte_q_t rand_body(input int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) q.push_back(8'($urandom));
    return q;
  endfunction

  // queues marker, length, body and checksum, cut after keep bytes
  function automatic int queue_frame(input byte_q_t body, input bit sum_ok, input int keep);
    byte_q_t     bytes;
    logic [15:0] code;
    logic [7:0]  sum;
    int          n;
    code = 16'(body.size() - 1);
    bytes.push_back(marker_cfg);
    bytes.push_back(code[15:8]);
    bytes.push_back(code[7:0]);
    foreach (body[i]) bytes.push_back(body[i]);
    sum = '0;
    foreach (bytes[i]) sum = sum + bytes[i];
    sum = 8'(8'd0 - sum);
    if (!sum_ok) sum = sum ^ 8'($urandom_range(1, 255));
    bytes.push_back(sum);
    n = 0;
    foreach (bytes[i]) begin
      if (i < keep) begin
        pending_bytes.push_back(bytes[i]);
        n++;
      end
    end
    return n;
  endfunction

  task automatic settle();
    while (pending_bytes.size() != 0 || rx_if.valid || predicted_beats.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_marker(input logic [7:0] v);
    @(negedge clk_i);
    cfg_if.valid                <= 1'b1;
    cfg_if.payload.start_marker <= v;
    do begin
      @(posedge clk_i);
    end while (!cfg_if.ready);
    marker_cfg = v;
    marker_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_mix(input int budget);
    int      sent;
    int      pick;
    int      n;
    byte_q_t body;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 9);
      n    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16);
      body = rand_body(n);
      if (pick < 7) begin
        sent += queue_frame(body, $urandom_range(0, 3) != 0, 1 << 30);
      end else if (pick < 9) begin
        repeat ($urandom_range(1, 4)) pending_bytes.push_back(8'($urandom));
      end else begin
        // frame cut short, the next bytes get swallowed by it
        sent += queue_frame(body, 1'b1, $urandom_range(1, n + 3));
      end
    end
  endtask

  // rx driver
  always @(negedge clk_i) begin
    if (rx_if.valid && !rx_took) begin
      // beat still waiting for ready
    end else if (rx_gap != 0) begin
      rx_if.valid <= 1'b0;
      rx_gap--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      rx_if.valid <= 1'b0;
      rx_gap = $urandom_range(0, 17);
    end else if (pending_bytes.size() != 0) begin
      rx_if.valid           <= 1'b1;
      rx_if.payload.rx_byte <= pending_bytes[0];
    end else begin
      rx_if.valid <= 1'b0;
    end
    rx_took = 1'b0;
  end

  // result backpressure
  always @(negedge clk_i) begin
    if (res_stall != 0) begin
      res_if.ready <= 1'b0;
      res_stall--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      res_if.ready <= 1'b0;
      res_stall = $urandom_range(0, 17);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // rx beat prediction and result checking
  always @(posedge clk_i) begin
    res_item_t want;
    res_item_t got;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("tb_top NOT OK");
      $finish;
    end else if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        deframe_byte(rx_if.payload.rx_byte);
        void'(pending_bytes.pop_front());
        rx_took = 1'b1;
        bytes_in++;
      end
      if (res_if.valid && res_if.ready) begin
        got = res_if.payload;
        if (predicted_beats.size() == 0) begin
          errors++;
          $display("%0t unexpected result beat: expected none, actual %0h", $time, got);
        end else begin
          want = predicted_beats.pop_front();
          check_field("event_res", 17'(want.event_res), 17'(got.event_res));
          check_field("payload_offset", 17'(want.payload_offset), 17'(got.payload_offset));
          check_field("payload_byte", 17'(want.payload_byte), 17'(got.payload_byte));
          check_field("frame_length", want.frame_length, got.frame_length);
          case (want.event_res)
            EV_PAYLOAD: payload_beats++;
            EV_GOOD:    frames_good++;
            EV_BAD:     frames_bad++;
            default: ;
          endcase
        end
      end
    end
  end

  initial begin
    byte_q_t big;
    int      unused;
    rst_ni                      = 1'b0;
    rx_if.valid                 = 1'b0;
    rx_if.payload               = '0;
    cfg_if.valid                = 1'b0;
    cfg_if.payload              = '0;
    res_if.ready                = 1'b0;
    calm                        = 1'b0;
    rx_took                     = 1'b0;
    rx_gap                      = 0;
    res_stall                   = 0;
    cycles                      = 0;
    errors                      = 0;
    bytes_in                    = 0;
    payload_beats               = 0;
    frames_good                 = 0;
    frames_bad                  = 0;
    marker_writes               = 0;
    marker_cfg                  = DefaultMarker;
    hunt_pos                    = PosHunt;
    frame_count                 = '0;
    frame_sum                   = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // reset marker, noise while no length seen yet
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h45);
    pending_bytes.push_back(8'h47);
    // shortest frame, payload equal to the marker
    unused = queue_frame('{8'h46}, 1'b1, 1 << 30);
    unused = queue_frame('{8'hFF, 8'h00, 8'hAA}, 1'b0, 1 << 30);
    unused = queue_frame('{8'h55, 8'hAA}, 1'b1, 1 << 30);
    // marker as length byte inside a frame
    pending_bytes.push_back(8'h46);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'h46);
    unused = queue_frame(rand_body(2), 1'b1, 1 << 30);
    settle();

    write_marker(8'h00);
    run_mix(70);
    settle();
    write_marker(8'hFF);
    run_mix(70);
    settle();
    write_marker(8'($urandom_range(1, 254)));
    run_mix(70);
    settle();

    // no idling from here on; two whole frames, then a maximum-length
    // header whose frame is cut off after 150 bytes
    calm = 1'b1;
    write_marker(DefaultMarker);
    unused = queue_frame(rand_body(20), 1'b1, 1 << 30);
    unused = queue_frame(rand_body(30), 1'b0, 1 << 30);
    big = rand_body(65536);
    unused = queue_frame(big, 1'b1, 150);

    while (pending_bytes.size() != 0 || predicted_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d bytes in, %0d payload beats, %0d good and %0d bad frames",
             bytes_in, payload_beats, frames_good, frames_bad);
    $display("%0d marker writes incl. 0x00 and 0xff, %0d errors", marker_writes, errors);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/lpfd_pkg.sv
hw/rtl/lpfd_stream_if.sv
hw/rtl/lpfd_in_stage.sv
hw/rtl/lpfd_core.sv
hw/rtl/length_prefixed_frame_deframer.sv
hw/rtl/lpfd_checker.sv
sim/tb_top.sv
